[hw/rtl/assert_macros.svh]
// Assertion macros shared by the dual stack RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, inactive while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

[hw/rtl/dss_pkg.sv]
// Package for the dual stack: operation and status codes, shared structs.
package dss_pkg;

   // Operation codes carried in req_mode
   localparam logic [1:0] MODE_PUSH = 2'd0;
   localparam logic [1:0] MODE_POP  = 2'd1;
   localparam logic [1:0] MODE_PEEK = 2'd2;

   // Result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [1:0] ST_UNDERFLOW = 2'd2;

   // Memory command from control to the store
   typedef struct packed {
      logic rd;
      logic wr;
   } mem_cmd_type;

   // Per-request result info that travels beside the memory read
   typedef struct packed {
      logic [1:0] status;
      logic       use_rd;
      logic       empty;
   } result_info_type;

endpackage

[hw/rtl/dss_mem.sv]
// Single-port synchronous store shared by both stacks.
module dss_mem
   import dss_pkg::*;
#(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 32,
   localparam int ADDR_W    = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  mem_cmd_type           cmd,
   input  logic [ADDR_W-1:0]     addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         mem[addr] <= wr_data;
      end
   end

   // registered read, held until the next read
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/dss_ctrl.sv]
// Stack pointer control: count registers, checks and store address generation.
`include "assert_macros.svh"
module dss_ctrl
   import dss_pkg::*;
#(
   parameter int DEPTH   = 1024,
   localparam int ADDR_W = $clog2(DEPTH),
   localparam int CNT_W  = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [1:0]        mode,
   input  logic              stack_select,
   output mem_cmd_type       cmd,
   output logic [ADDR_W-1:0] addr,
   output result_info_type   info,
   output logic [CNT_W-1:0]  count
);

   logic [CNT_W-1:0] lower_ff, lower_in;
   logic [CNT_W-1:0] upper_ff, upper_in;
   logic [CNT_W:0]   total;
   logic             full;
   logic [CNT_W-1:0] sel_cnt;
   logic [CNT_W-1:0] addr_wide;
   logic [CNT_W-1:0] cnt_after;

   assign total   = {1'b0, lower_ff} + {1'b0, upper_ff};
   assign full    = total >= (CNT_W + 1)'(DEPTH);
   assign sel_cnt = stack_select ? upper_ff : lower_ff;

   // decode the request against the current counts
   always_comb begin
      lower_in    = lower_ff;
      upper_in    = upper_ff;
      cmd         = '0;
      addr_wide   = '0;
      info.status = ST_OK;
      info.use_rd = 1'b0;
      unique case (mode)
         MODE_PUSH: begin
            if (full) begin
               info.status = ST_OVERFLOW;
            end else if (stack_select) begin
               cmd.wr    = accept;
               addr_wide = CNT_W'(DEPTH - 1) - upper_ff;
               upper_in  = upper_ff + 1'b1;
            end else begin
               cmd.wr    = accept;
               addr_wide = lower_ff;
               lower_in  = lower_ff + 1'b1;
            end
         end
         MODE_POP, MODE_PEEK: begin
            if (sel_cnt == '0) begin
               info.status = ST_UNDERFLOW;
            end else begin
               cmd.rd      = accept;
               info.use_rd = 1'b1;
               if (stack_select) begin
                  addr_wide = CNT_W'(DEPTH) - upper_ff;
                  if (mode == MODE_POP) begin
                     upper_in = upper_ff - 1'b1;
                  end
               end else begin
                  addr_wide = lower_ff - 1'b1;
                  if (mode == MODE_POP) begin
                     lower_in = lower_ff - 1'b1;
                  end
               end
            end
         end
         default: begin
            // unused code: no state change, report counts only
         end
      endcase
      cnt_after  = stack_select ? upper_in : lower_in;
      info.empty = (cnt_after == '0);
   end

   assign addr  = addr_wide[ADDR_W-1:0];
   assign count = cnt_after;

   // count registers, updated only on an accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff <= '0;
         upper_ff <= '0;
      end else if (accept) begin
         lower_ff <= lower_in;
         upper_ff <= upper_in;
      end
   end

   `ASSERT_CLK(a_total_bound, total <= (CNT_W + 1)'(DEPTH), "stacks hold more than DEPTH words")
   `ASSERT_CLK(a_push_grows, accept && cmd.wr |=> total == $past(total) + 1'b1, "push did not add one word")
   `ASSERT_CLK(a_fail_keeps, accept && info.status != ST_OK |=> $stable(lower_ff) && $stable(upper_ff), "failed request changed a count")

endmodule

[hw/rtl/dual_stack_shared_memory.sv]
// Usage notes for the dual stack block:
//   Two LIFO stacks share one DEPTH-word store; the lower stack grows up from
//   address 0, the upper one grows down from address DEPTH-1.
//   Request channel (req_*): mode (push, pop, peek), stack_select and
//   push_value. A request is taken on a clock edge with req_valid high and
//   req_stall low.
//   Response channel (rsp_*): read_data, status, selected_count and
//   selected_empty; one response per request, in request order, taken on an
//   edge with rsp_valid high and rsp_stall low.
//   Path: a taken request passes the store read stage, then the output
//   register, before its response is valid.
//   Throughput: one request per cycle while req_stall is low, set by the
//   single store port, which serves one read or one write for each request.
//   When rsp_stall is held, the output register and the read stage fill,
//   and req_stall rises; nothing is dropped.
//   Reset (synchronous, active high) clears both counts and the pipeline;
//   the store contents are not cleared and no clearing pass is run.
`include "assert_macros.svh"
module dual_stack_shared_memory
   import dss_pkg::*;
#(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 32,
   localparam int ADDR_W    = $clog2(DEPTH),
   localparam int CNT_W     = $clog2(DEPTH + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_mode,
   input  logic                         req_stack_select,
   input  logic signed [DATA_WIDTH-1:0] req_push_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_read_data,
   output logic [1:0]                   rsp_status,
   output logic [CNT_W-1:0]             rsp_selected_count,
   output logic                         rsp_selected_empty
);

   logic                  accept;
   logic                  s1_move;
   mem_cmd_type           mem_cmd;
   logic [ADDR_W-1:0]     mem_addr;
   logic [DATA_WIDTH-1:0] mem_rd_data;
   result_info_type       ctrl_info;
   logic [CNT_W-1:0]      ctrl_count;

   logic                  s1_valid_ff, s1_valid_in;
   result_info_type       s1_info_ff;
   logic [CNT_W-1:0]      s1_count_ff;

   logic                  out_valid_ff, out_valid_in;
   logic [DATA_WIDTH-1:0] out_data_ff;
   logic [1:0]            out_status_ff;
   logic [CNT_W-1:0]      out_count_ff;
   logic                  out_empty_ff;

   // handshake: read stage drains into the output register when it is free
   assign s1_move   = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_move;
   assign accept    = req_valid && !req_stall;

   dss_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .mode         (req_mode),
      .stack_select (req_stack_select),
      .cmd          (mem_cmd),
      .addr         (mem_addr),
      .info         (ctrl_info),
      .count        (ctrl_count)
   );

   dss_mem #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_mem (
      .clock   (clock),
      .cmd     (mem_cmd),
      .addr    (mem_addr),
      .wr_data (req_push_value),
      .rd_data (mem_rd_data)
   );

   // valid bits of the read stage and the output register
   always_comb begin
      s1_valid_in  = accept || (s1_valid_ff && !s1_move);
      out_valid_in = s1_move || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // read stage payload: result info waits beside the store read
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_info_ff  <= ctrl_info;
         s1_count_ff <= ctrl_count;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_data_ff   <= s1_info_ff.use_rd ? mem_rd_data : '0;
         out_status_ff <= s1_info_ff.status;
         out_count_ff  <= s1_count_ff;
         out_empty_ff  <= s1_info_ff.empty;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_read_data      = out_data_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_selected_count = out_count_ff;
   assign rsp_selected_empty = out_empty_ff;

   `ASSERT_CLK(a_underflow_empty, rsp_valid && rsp_status == ST_UNDERFLOW |-> rsp_selected_empty, "underflow reported on a non-empty stack")
   `ASSERT_NEVER(a_fail_data, rsp_valid && rsp_status != ST_OK && rsp_read_data != '0, "failed request returned nonzero data")
   `ASSERT_CLK(a_full_blocks, s1_valid_ff && out_valid_ff && rsp_stall |-> req_stall, "request taken with the pipeline full")

endmodule

[verif/dual_stack_shared_memory_tb.sv]
// Testbench for the dual stack block: random push/pop/peek traffic checked against a predictor.
`timescale 1ns / 100ps

// One predicted response
typedef struct {
   logic [31:0] read_data;
   logic [1:0]  status;
   logic [10:0] count;
   logic        empty;
} stack_reply_type;

// Predicts responses from accepted requests and checks them in order
class dual_stack_scoreboard;
   localparam int STACK_DEPTH = 1024;

   logic [31:0]     store [STACK_DEPTH];
   int unsigned     lower_count;
   int unsigned     upper_count;
   stack_reply_type predicted_replies [$];
   int unsigned     failures;

   function new();
      lower_count = 0;
      upper_count = 0;
      failures    = 0;
   endfunction

   // Apply one accepted request to the stack copy and queue its response
   function void note_request(logic [1:0] mode, logic sel, logic [31:0] value);
      stack_reply_type r;
      int unsigned     cnt;
      r.read_data = '0;
      r.status    = dss_pkg::ST_OK;
      case (mode)
         dss_pkg::MODE_PUSH: begin
            if (lower_count + upper_count >= STACK_DEPTH) begin
               r.status = dss_pkg::ST_OVERFLOW;
            end else if (sel) begin
               upper_count++;
               store[STACK_DEPTH - upper_count] = value;
            end else begin
               store[lower_count] = value;
               lower_count++;
            end
         end
         dss_pkg::MODE_POP, dss_pkg::MODE_PEEK: begin
            cnt = sel ? upper_count : lower_count;
            if (cnt == 0) begin
               r.status = dss_pkg::ST_UNDERFLOW;
            end else if (sel) begin
               r.read_data = store[STACK_DEPTH - upper_count];
               if (mode == dss_pkg::MODE_POP) upper_count--;
            end else begin
               r.read_data = store[lower_count - 1];
               if (mode == dss_pkg::MODE_POP) lower_count--;
            end
         end
         default: ;  // unused mode: no state change
      endcase
      cnt     = sel ? upper_count : lower_count;
      r.count = cnt[10:0];
      r.empty = (cnt == 0);
      predicted_replies.push_back(r);
   endfunction

   // Compare one accepted response with the oldest prediction
   function void check_response(logic [31:0] data, logic [1:0] status, logic [10:0] count,
                                logic empty);
      stack_reply_type e;
      if (predicted_replies.size() == 0) begin
         $error("response with no request outstanding");
         failures++;
         return;
      end
      e = predicted_replies.pop_front();
      if (data !== e.read_data) begin
         $error("read_data: expected %08h, got %08h", e.read_data, data);
         failures++;
      end
      if (status !== e.status) begin
         $error("status: expected %0d, got %0d", e.status, status);
         failures++;
      end
      if (count !== e.count) begin
         $error("selected_count: expected %0d, got %0d", e.count, count);
         failures++;
      end
      if (empty !== e.empty) begin
         $error("selected_empty: expected %0b, got %0b", e.empty, empty);
         failures++;
      end
   endfunction

   function int unsigned pending();
      return predicted_replies.size();
   endfunction
endclass

module dual_stack_shared_memory_tb;
   import dss_pkg::*;

   localparam logic [1:0] MODE_UNUSED  = 2'd3;
   localparam int         DEPTH        = 1024;
   localparam int         RANDOM_ITEMS = 1425;
   localparam int         PHASE_LEN    = RANDOM_ITEMS / 4;

   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic               req_stall;
   logic [1:0]         req_mode         = MODE_PUSH;
   logic               req_stack_select = 1'b0;
   logic signed [31:0] req_push_value   = '0;
   logic               rsp_valid;
   logic               rsp_stall        = 1'b0;
   logic signed [31:0] rsp_read_data;
   logic [1:0]         rsp_status;
   logic [10:0]        rsp_selected_count;
   logic               rsp_selected_empty;

   int unsigned          send_idle_pct = 0;
   int unsigned          rsp_stall_pct = 0;
   dual_stack_scoreboard board;

   dual_stack_shared_memory uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_stack_select   (req_stack_select),
      .req_push_value     (req_push_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_read_data      (rsp_read_data),
      .rsp_status         (rsp_status),
      .rsp_selected_count (rsp_selected_count),
      .rsp_selected_empty (rsp_selected_empty)
   );

   always #2 clock = ~clock;

   // Random backpressure on the response side
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else       rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_response(rsp_read_data, rsp_status, rsp_selected_count,
                              rsp_selected_empty);
   end

   // Present one request, hold it until taken, then record it
   task automatic send_request(input logic [1:0] mode, input logic sel,
                               input logic [31:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_stack_select <= sel;
      req_push_value   <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(mode, sel, value);
   endtask

   // Hold off new requests until every response is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   // Push data: mostly random, sometimes an extreme value
   function automatic logic [31:0] pick_value();
      logic [31:0] corners [4];
      corners = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
      if ($urandom_range(15) == 0) return corners[$urandom_range(3)];
      return $urandom;
   endfunction

   // Weighted operation choice; the remainder goes to the unused mode
   function automatic logic [1:0] pick_mode(int unsigned push_w, int unsigned pop_w,
                                            int unsigned peek_w);
      int unsigned r;
      r = $urandom_range(99);
      if (r < push_w)                 return MODE_PUSH;
      if (r < push_w + pop_w)         return MODE_POP;
      if (r < push_w + pop_w + peek_w) return MODE_PEEK;
      return MODE_UNUSED;
   endfunction

   // Main stimulus
   initial begin
      bit          filling;
      int unsigned full_hits;
      int unsigned phase;
      logic [1:0]  mode;

      board = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty stacks, unused mode, extremes, back-to-back push/pop
      send_request(MODE_PEEK,   1'b0, 32'h0);
      send_request(MODE_POP,    1'b0, 32'h0);
      send_request(MODE_PEEK,   1'b1, 32'h0);
      send_request(MODE_POP,    1'b1, 32'h0);
      send_request(MODE_UNUSED, 1'b0, 32'hFFFF_FFFF);
      send_request(MODE_UNUSED, 1'b1, 32'h1234_5678);
      send_request(MODE_PUSH,   1'b0, 32'h7FFF_FFFF);
      send_request(MODE_PUSH,   1'b0, 32'h8000_0000);
      send_request(MODE_PUSH,   1'b0, 32'h0000_0000);
      send_request(MODE_PUSH,   1'b0, 32'hFFFF_FFFF);
      send_request(MODE_PUSH,   1'b1, 32'h8000_0000);
      send_request(MODE_PUSH,   1'b1, 32'h7FFF_FFFF);
      send_request(MODE_POP,    1'b1, 32'h0);
      send_request(MODE_PUSH,   1'b1, 32'hA5A5_A5A5);
      send_request(MODE_PEEK,   1'b1, 32'h0);
      send_request(MODE_UNUSED, 1'b0, 32'h0);
      send_request(MODE_PEEK,   1'b0, 32'h0);
      send_request(MODE_POP,    1'b0, 32'h0);
      send_request(MODE_POP,    1'b0, 32'h0);
      send_request(MODE_PUSH,   1'b0, 32'h5A5A_5A5A);
      send_request(MODE_POP,    1'b0, 32'h0);
      send_request(MODE_POP,    1'b1, 32'h0);
      send_request(MODE_POP,    1'b1, 32'h0);
      send_request(MODE_POP,    1'b1, 32'h0);

      // Random: fill both stacks to the full memory, press on overflow, then drain
      filling   = 1'b1;
      full_hits = 0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % PHASE_LEN == 0) begin
            wait_drained();
            phase = i / PHASE_LEN;
            case (phase)
               0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
               1:       begin send_idle_pct = 53; rsp_stall_pct = 0;  end
               2:       begin send_idle_pct = 0;  rsp_stall_pct = 53; end
               default: begin send_idle_pct = 17; rsp_stall_pct = 17; end
            endcase
         end
         if (board.lower_count + board.upper_count == DEPTH) begin
            full_hits++;
            if (full_hits >= 12) filling = 1'b0;
         end
         if (!filling && board.lower_count + board.upper_count == 0) begin
            filling   = 1'b1;
            full_hits = 0;
         end
         mode = filling ? pick_mode(93, 3, 2) : pick_mode(15, 60, 18);
         send_request(mode, 1'($urandom_range(1)), pick_value());
      end

      // Wind down and give the pipeline time to empty
      wait_drained();
      repeat (8) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0)
         $display("[dual_stack_shared_memory] OK");
      else
         $display("[dual_stack_shared_memory] ERROR");
      $finish;
   end

   // Run limit
   initial begin
      #2_000_000;
      $display("[dual_stack_shared_memory] ERROR");
      $finish;
   end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/dss_pkg.sv
hw/rtl/dss_mem.sv
hw/rtl/dss_ctrl.sv
hw/rtl/dual_stack_shared_memory.sv
verif/dual_stack_shared_memory_tb.sv
